@@ hw/rtl/sob_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sob_pkg
// shared types, sizes and register codes of the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sob_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // position of an emitted row or column relative to the interior one
    localparam logic [1:0] SEL_LOW  = 2'd0;
    localparam logic [1:0] SEL_MID  = 2'd1;
    localparam logic [1:0] SEL_HIGH = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] mag;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       row_start;
        logic [1:0]       row_end;
        logic [1:0]       col_start;
        logic [1:0]       col_end;
    } sob_job_t;

    function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] fw);
        logic [FW_W-1:0] w;
        w = fw;
        if (fw < FW_W'(3))
            w = FW_W'(3);
        else if (fw > FW_W'(MAX_WIDTH))
            w = FW_W'(MAX_WIDTH);
        return w;
    endfunction

    function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] fh);
        logic [FH_W-1:0] h;
        h = fh;
        if (fh < FH_W'(3))
            h = FH_W'(3);
        else if (fh > FH_W'(MAX_HEIGHT))
            h = FH_W'(MAX_HEIGHT);
        return h;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sob_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sob_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/sob_grad.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sob_grad
// 3x3 sobel kernel pair, |gx| + |gy| saturated to 8 bits
// ----------------------------------------------------------------------------
module sob_grad
    import sob_pkg::*;
(
    input  wire logic [PIX_W-1:0] t0,
    input  wire logic [PIX_W-1:0] t1,
    input  wire logic [PIX_W-1:0] t2,
    input  wire logic [PIX_W-1:0] m0,
    input  wire logic [PIX_W-1:0] m2,
    input  wire logic [PIX_W-1:0] b0,
    input  wire logic [PIX_W-1:0] b1,
    input  wire logic [PIX_W-1:0] b2,
    output logic      [PIX_W-1:0] mag
);

    localparam int SUM_W = PIX_W + 2;

    logic [SUM_W-1:0] top_sum;
    logic [SUM_W-1:0] bot_sum;
    logic [SUM_W-1:0] left_sum;
    logic [SUM_W-1:0] right_sum;
    logic [SUM_W-1:0] abs_gx;
    logic [SUM_W-1:0] abs_gy;
    logic [SUM_W:0]   total;

    always_comb
    begin
        top_sum   = SUM_W'(t0) + {1'b0, t1, 1'b0} + SUM_W'(t2);
        bot_sum   = SUM_W'(b0) + {1'b0, b1, 1'b0} + SUM_W'(b2);
        left_sum  = SUM_W'(t0) + {1'b0, m0, 1'b0} + SUM_W'(b0);
        right_sum = SUM_W'(t2) + {1'b0, m2, 1'b0} + SUM_W'(b2);
        abs_gx    = (bot_sum >= top_sum) ? (bot_sum - top_sum) : (top_sum - bot_sum);
        abs_gy    = (left_sum >= right_sum) ? (left_sum - right_sum) : (right_sum - left_sum);
        total     = {1'b0, abs_gx} + {1'b0, abs_gy};
        // clamp at full scale
        if (total > (SUM_W + 1)'(255))
            mag = '1;
        else
            mag = total[PIX_W-1:0];
    end

endmodule
`default_nettype wire

@@ hw/rtl/sob_burst.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sob_burst
// expands one interior result into its border copies, with output register
// ----------------------------------------------------------------------------
module sob_burst
    import sob_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_load,
    input  wire sob_job_t         job_in,
    output logic                  job_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [ROW_W-1:0] out_row,
    output logic      [COL_W-1:0] out_col,
    output logic      [PIX_W-1:0] edge_value,
    output logic                  last_of_run,
    output logic                  frame_done
);

    sob_job_t         job_reg;
    logic             job_valid_reg;
    logic [1:0]       row_sel_reg;
    logic [1:0]       col_sel_reg;
    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [PIX_W-1:0] edge_value_reg;
    logic             last_of_run_reg;
    logic             frame_done_reg;

    logic             out_load;
    logic             job_last;
    logic [ROW_W-1:0] row_value;
    logic [COL_W-1:0] col_value;

    always_comb
    begin
        out_load = job_valid_reg && (!out_valid_reg || out_ready);
        job_last = (row_sel_reg == job_reg.row_end) && (col_sel_reg == job_reg.col_end);
        job_free = !job_valid_reg || (out_load && job_last);
        unique case (row_sel_reg)
            SEL_LOW:  row_value = '0;
            SEL_MID:  row_value = job_reg.row;
            SEL_HIGH: row_value = job_reg.row + ROW_W'(1);
            default:  row_value = job_reg.row;
        endcase
        unique case (col_sel_reg)
            SEL_LOW:  col_value = '0;
            SEL_MID:  col_value = job_reg.col;
            SEL_HIGH: col_value = job_reg.col + COL_W'(1);
            default:  col_value = job_reg.col;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            row_sel_reg   <= SEL_MID;
            col_sel_reg   <= SEL_MID;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            row_sel_reg   <= job_in.row_start;
            col_sel_reg   <= job_in.col_start;
        end
        else if (out_load)
        begin
            if (job_last)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (col_sel_reg == job_reg.col_end)
            begin
                col_sel_reg <= job_reg.col_start;
                row_sel_reg <= row_sel_reg + 2'd1;
            end
            else
            begin
                col_sel_reg <= col_sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg     <= row_value;
            out_col_reg     <= col_value;
            edge_value_reg  <= job_reg.mag;
            last_of_run_reg <= job_last;
            // only the bottom-right copy can sit on the last row and column
            frame_done_reg  <= (row_sel_reg == SEL_HIGH) && (col_sel_reg == SEL_HIGH);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign edge_value  = edge_value_reg;
    assign last_of_run = last_of_run_reg;
    assign frame_done  = frame_done_reg;

endmodule
`default_nettype wire

@@ hw/rtl/sobel_edge_magnitude_3x3.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3
// streaming 3x3 sobel |gx|+|gy| with border replication
//
// gray pixels enter in raster order on the in_valid / in_ready channel, one
// transfer per pixel. results leave on out_valid / out_ready, each tagged with
// out_row, out_col, last_of_run and frame_done. frame size comes from two apb
// registers (frame_width at 0x0, frame_height at 0x4); any write restarts the
// frame at row 0, column 0 and keeps the line buffer contents.
// results pass the input stage, the burst job register and the output register.
// throughput, while out_ready is high: one pixel per clock if each pixel causes
// at most one result; a pixel next to a border causes up to nine results, which
// the burst unit emits one per clock, holding in_ready low until all of them are
// handed to the output register. the limit is the single output register.
// the first two rows and first two columns of a frame cause no results.
// line buffers are two 8-bit x 1024 rams, read when a pixel is taken and
// written back as the pixel leaves the input stage; no clearing pass is needed.
// reset empties the pipeline, sets the frame size to 640 x 480 and zeroes
// the row and column counters. when the receiver stalls, the output register
// holds its result, the burst unit and the input stage fill, then in_ready
// drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3
    import sob_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [PIX_W-1:0]  pixel,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [ROW_W-1:0]  out_row,
    output logic      [COL_W-1:0]  out_col,
    output logic      [PIX_W-1:0]  edge_value,
    output logic                   last_of_run,
    output logic                   frame_done
);

    // configuration registers
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [FW_W-1:0]  width_eff;
    logic [FH_W-1:0]  height_eff;
    logic             cfg_write;

    // raster position of the next pixel
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic             in_xfer;
    logic             col_wrap;
    logic             row_wrap;

    // input stage, line buffer read data lines up with it
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_emits;
    logic             s1_consume;
    logic [PIX_W-1:0] above_q;
    logic [PIX_W-1:0] two_above_q;

    // two previous columns: top, middle, bottom of each
    logic [PIX_W-1:0] win_reg [6];

    logic [PIX_W-1:0] mag;
    sob_job_t         job;
    logic             job_free;
    logic             job_load;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        width_eff  = eff_width(frame_width_reg);
        height_eff = eff_height(frame_height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- counters
    always_comb
    begin
        in_ready = !s1_valid_reg || s1_consume;
        in_xfer  = in_valid && in_ready;
        col_wrap = ({1'b0, col_count_reg} + FW_W'(1)) >= width_eff;
        row_wrap = ({1'b0, row_count_reg} + FH_W'(1)) >= height_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            // any register write restarts the frame
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (col_wrap)
            begin
                col_count_reg <= '0;
                row_count_reg <= row_wrap ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------- line buffers
    sob_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk     (clk),
        .wr_en   (s1_consume),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (in_xfer),
        .rd_addr (col_count_reg),
        .rd_data (above_q)
    );

    sob_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .clk     (clk),
        .wr_en   (s1_consume),
        .wr_addr (s1_col_reg),
        .wr_data (above_q),
        .rd_en   (in_xfer),
        .rd_addr (col_count_reg),
        .rd_data (two_above_q)
    );

    // ---------------------------------------------------------------- input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_consume)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_count_reg;
            s1_row_reg   <= row_count_reg;
        end
    end

    // window slides once per pixel as it leaves the input stage
    always_ff @(posedge clk)
    begin
        if (s1_consume)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= two_above_q;
            win_reg[4] <= above_q;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    sob_grad u_grad (
        .t0  (win_reg[0]),
        .t1  (win_reg[3]),
        .t2  (two_above_q),
        .m0  (win_reg[1]),
        .m2  (above_q),
        .b0  (win_reg[2]),
        .b1  (win_reg[5]),
        .b2  (s1_pixel_reg),
        .mag (mag)
    );

    // interior result at (row-1, col-1) plus its border neighbors
    always_comb
    begin
        s1_emits      = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2));
        s1_consume    = s1_valid_reg && (!s1_emits || job_free);
        job_load      = s1_valid_reg && s1_emits && job_free;
        job.mag       = mag;
        job.row       = s1_row_reg - ROW_W'(1);
        job.col       = s1_col_reg - COL_W'(1);
        job.row_start = (s1_row_reg == ROW_W'(2)) ? SEL_LOW : SEL_MID;
        job.row_end   = ({1'b0, s1_row_reg} == height_eff - FH_W'(1)) ? SEL_HIGH : SEL_MID;
        job.col_start = (s1_col_reg == COL_W'(2)) ? SEL_LOW : SEL_MID;
        job.col_end   = ({1'b0, s1_col_reg} == width_eff - FW_W'(1)) ? SEL_HIGH : SEL_MID;
    end

    sob_burst u_burst (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_load    (job_load),
        .job_in      (job),
        .job_free    (job_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .edge_value  (edge_value),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

    // ---------------------------------------------------------------- checks
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame_done without last_of_run");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_count_reg} < width_eff)
        else $error("column counter outside frame width");

    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_consume |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("input stage dropped a pixel");

    a_not_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_emits && !job_free)
        else $error("in_ready low with a free pipeline");

    a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_col} < width_eff))
        else $error("result column outside frame width");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming 3x3 sobel edge magnitude block
//
// pixels go in on a valid/ready channel with random gaps, results come out
// on a valid/ready channel with random back-pressure. a scoreboard object
// keeps its own line buffers, window and counters, works out every result a
// pixel transfer should cause (border copies included) and checks each result
// transfer field by field in order. frame size is set over apb between phases
// and read back. phases: a few tiny directed frames, many small random
// frames, a gap-free frame, then a short run with the width above range.
// ----------------------------------------------------------------------------
module tb_top;
    import sob_pkg::*;

    localparam int SETTLE_CYCLES = 16;        // pipeline depth plus burst slack
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PIXELS = 330;

    // one result transfer as the block should present it
    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] mag;
        logic             last;
        logic             done;
    } edge_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the frame geometry, line buffers and window;
    // every accepted pixel pushes the results it causes, every result
    // transfer pops the oldest one and compares
    // ------------------------------------------------------------------------
    class edge_scoreboard;
        logic [FW_W-1:0]  fw;
        logic [FH_W-1:0]  fh;
        logic [PIX_W-1:0] line_up1 [MAX_WIDTH];
        logic [PIX_W-1:0] line_up2 [MAX_WIDTH];
        logic [PIX_W-1:0] win [6];
        int               row_cnt;
        int               col_cnt;
        edge_result_t     edges_due[$];
        int               errors;

        function new();
            fw = FRAME_WIDTH_RST;
            fh = FRAME_HEIGHT_RST;
            foreach (line_up1[i])
            begin
                line_up1[i] = '0;
                line_up2[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            row_cnt = 0;
            col_cnt = 0;
            errors  = 0;
        endfunction

        function int width_used();
            if (fw < 3)
                return 3;
            if (fw > MAX_WIDTH)
                return MAX_WIDTH;
            return fw;
        endfunction

        function int height_used();
            if (fh < 3)
                return 3;
            if (fh > MAX_HEIGHT)
                return MAX_HEIGHT;
            return fh;
        endfunction

        function int pending();
            return edges_due.size();
        endfunction

        // any register write restarts the frame, buffers are kept
        function void write_reg(logic idx, logic [DATA_W-1:0] data);
            if (idx == REG_FRAME_WIDTH)
                fw = data[FW_W-1:0];
            else
                fh = data[FH_W-1:0];
            row_cnt = 0;
            col_cnt = 0;
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pix);
            int w, h, y, x;
            int t0, m0, b0, t1, b1, t2, m2, b2, gx, gy, mag;
            int rows[$];
            int cols[$];
            logic [PIX_W-1:0] top, mid;
            edge_result_t e;
            w   = width_used();
            h   = height_used();
            y   = row_cnt;
            x   = col_cnt;
            top = line_up2[x];
            mid = line_up1[x];
            t0  = win[0];
            m0  = win[1];
            b0  = win[2];
            t1  = win[3];
            b1  = win[5];
            t2  = top;
            m2  = mid;
            b2  = pix;
            gx  = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
            gy  = (t0 - t2) + 2 * (m0 - m2) + (b0 - b2);
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > 255)
                mag = 255;
            if (y >= 2 && x >= 2 && y < h && x < w)
            begin
                // interior point plus the border rows/cols it stands in for
                if (y - 1 == 1)
                    rows.push_back(0);
                rows.push_back(y - 1);
                if (y - 1 == h - 2)
                    rows.push_back(h - 1);
                if (x - 1 == 1)
                    cols.push_back(0);
                cols.push_back(x - 1);
                if (x - 1 == w - 2)
                    cols.push_back(w - 1);
                for (int i = 0; i < rows.size(); i++)
                begin
                    for (int j = 0; j < cols.size(); j++)
                    begin
                        e.row  = ROW_W'(rows[i]);
                        e.col  = COL_W'(cols[j]);
                        e.mag  = PIX_W'(mag);
                        e.last = (i == rows.size() - 1) && (j == cols.size() - 1);
                        e.done = (rows[i] == h - 1) && (cols[j] == w - 1);
                        edges_due.push_back(e);
                    end
                end
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = pix;
            line_up2[x] = mid;
            line_up1[x] = pix;
            if (x + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (y + 1 >= h) ? 0 : y + 1;
            end
            else
                col_cnt = x + 1;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_edge(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                        input logic [PIX_W-1:0] mag, input logic last,
                        input logic done);
            edge_result_t e;
            if (edges_due.size() == 0)
            begin
                report($sformatf("unexpected result row %0d col %0d", row, col));
                return;
            end
            e = edges_due.pop_front();
            if (row !== e.row)
                report($sformatf("out_row got %0d want %0d", row, e.row));
            if (col !== e.col)
                report($sformatf("out_col got %0d want %0d (row %0d)", col, e.col, e.row));
            if (mag !== e.mag)
                report($sformatf("edge_value got %0d want %0d at (%0d,%0d)",
                                 mag, e.mag, e.row, e.col));
            if (last !== e.last)
                report($sformatf("last_of_run got %b want %b at (%0d,%0d)",
                                 last, e.last, e.row, e.col));
            if (done !== e.done)
                report($sformatf("frame_done got %b want %b at (%0d,%0d)",
                                 done, e.done, e.row, e.col));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals, all bench-driven inputs known from time zero
    // ------------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [PIX_W-1:0]  pixel     = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic [PIX_W-1:0]  edge_value;
    logic              last_of_run;
    logic              frame_done;

    logic              no_stall  = 1'b0;  // long stretch with no gaps on either side
    int                cycle_count = 0;
    edge_scoreboard    board;

    sobel_edge_magnitude_3x3 DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .edge_value  (edge_value),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

    always #2 clk = ~clk;

    // receiver: random back-pressure, out_ready held low with a 27 percent chance
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_stall || ($urandom_range(99) >= 27);
    end

    // result monitor, sees the values from before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_edge(out_row, out_col, edge_value, last_of_run, frame_done);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // apb write (setup + access), then read the register back
    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.write_reg(idx, data);
        // read-back: only the register's own bits are kept
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            want = DATA_W'(data[FW_W-1:0]);
        else
            want = DATA_W'(data[FH_W-1:0]);
        if (prdata !== want)
            board.report($sformatf("prdata reg %0d got %h want %h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] hd);
        write_reg(REG_FRAME_WIDTH, wd);
        write_reg(REG_FRAME_HEIGHT, hd);
    endtask

    // one pixel transfer, idle cycles in front of it at random
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while (!no_stall && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.take_pixel(value);
    endtask

    // stop sending until every expected result is out, then let the
    // pipeline settle (pixels that cause no result may still be inside)
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly uniform, with plenty of black and white
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] mixed_3x3 [9] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F,
                                       8'hF0, 8'h33, 8'hCC, 8'h81};
    logic [PIX_W-1:0] vert_3x3  [9] = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00,
                                       8'h00, 8'hFF, 8'h00, 8'h00};
    logic [PIX_W-1:0] horiz_3x3 [9] = '{8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h08,
                                       8'h09, 8'h00, 8'h00, 8'h00};

    initial
    begin
        int               sent;
        int               count;
        int               pause_at;
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] hd;

        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // narrow 3x3 frame: the single interior point spreads to all nine
        set_frame(32'd3, 32'd3);
        foreach (mixed_3x3[i])
            send_pixel(mixed_3x3[i]);
        drain();

        // sizes below range (upper data bits set, register bits 0 and 1),
        // vertical edge that saturates |gy|
        set_frame(32'hFFFF_F800, 32'hFFFF_E001);
        foreach (vert_3x3[i])
            send_pixel(vert_3x3[i]);
        drain();

        // height above range, horizontal edge that saturates |gx|
        set_frame(32'd3, 32'h0000_1FFF);
        foreach (horiz_3x3[i])
            send_pixel(horiz_3x3[i]);
        drain();

        // small random frames, each phase restarts mid-frame at its end
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            wd = $urandom;
            hd = $urandom;
            if ($urandom_range(19) < 3)
                wd[FW_W-1:0] = FW_W'($urandom_range(2));
            else
                wd[FW_W-1:0] = FW_W'($urandom_range(12, 3));
            case ($urandom_range(19))
                0, 1:    hd[FH_W-1:0] = FH_W'($urandom_range(2));
                2, 3:    hd[FH_W-1:0] = FH_W'($urandom_range(8191, 4096));
                default: hd[FH_W-1:0] = FH_W'($urandom_range(8, 3));
            endcase
            set_frame(wd, hd);
            count    = $urandom_range(90, 30);
            pause_at = $urandom_range(count - 1);
            for (int i = 0; i < count; i++)
            begin
                // sender holds off until the block has caught up
                if (i == pause_at)
                    drain();
                send_pixel(pick_pixel());
            end
            sent += count;
            drain();
        end

        // full frame plus a wrap, no gaps on either side
        no_stall = 1'b1;
        set_frame(32'd16, 32'd5);
        for (int i = 0; i < 16 * 5 + 8; i++)
            send_pixel(pick_pixel());
        drain();
        no_stall = 1'b0;

        // width above range, height below range: a short run into the first row
        set_frame(32'h0000_07FF, 32'd2);
        for (int i = 0; i < 12; i++)
            send_pixel(pick_pixel());
        drain();

        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sobel_edge_magnitude_3x3.f @@
hw/rtl/sob_pkg.sv
hw/rtl/sob_ram.sv
hw/rtl/sob_grad.sv
hw/rtl/sob_burst.sv
hw/rtl/sobel_edge_magnitude_3x3.sv
tb/sv/tb_top.sv
